// ----- src/sieve_cache_replacement_assert.svh -----
// Assertion macros for the SIEVE replacement block and its port checker.
// No dependencies; the including module supplies i_clk and i_rst_n.
`ifndef SIEVE_CACHE_REPLACEMENT_ASSERT_SVH
`define SIEVE_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/scr_pkg.sv -----
// Shared types and constants of the SIEVE replacement block.
// No dependencies.
`default_nettype none

package scr_pkg;

    localparam int CAPACITY_MAX_DEF = 64;
    localparam int ID_BITS_DEF      = 32;
    localparam int OBJ_W            = 32;
    localparam int CAP_W            = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes
    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_PROBE  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Register index (byte address bit 2)
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]       operation;
        logic [OBJ_W-1:0] object_id;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic             evicted_valid;
        logic [OBJ_W-1:0] evicted_id;
    } t_rsp;

endpackage

`default_nettype wire

// ----- src/scr_ram.sv -----
// Simple memory: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module scr_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);

    logic [W-1:0] r_mem [D];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/sieve_cache_replacement.sv -----
// SIEVE replacement controller: sequencer, presence flags and list memories.
// Depends on scr_pkg and scr_ram.
//
// Each request (access, probe or remove) is taken when start is high and busy is
// low, and its one result appears on o_rsp for a single cycle with o_done; the
// receiver cannot stall, so it must take the result in that cycle. Lookup walks
// the id memory's single read port one slot per cycle. A remove then unlinks the
// entry. A miss inserts the new id at the head, after an eviction while the
// occupancy has reached the capacity; each eviction moves the hand past visited
// entries (at most CAPACITY_MAX per lap). After reset the block is ready at once.
`default_nettype none

module sieve_cache_replacement #(
    parameter int CAPACITY_MAX = scr_pkg::CAPACITY_MAX_DEF,
    parameter int ID_BITS      = scr_pkg::ID_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire scr_pkg::t_req i_req,
    output logic              o_done,
    output scr_pkg::t_rsp     o_rsp,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import scr_pkg::*;

    localparam int SW = $clog2(CAPACITY_MAX);
    localparam int CW = $clog2(CAPACITY_MAX + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CW-1:0] NIL = CW'(CAPACITY_MAX);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FIND   = 4'd1;
    localparam logic [3:0] ST_DISP   = 4'd2;
    localparam logic [3:0] ST_RM_RD  = 4'd3;
    localparam logic [3:0] ST_UNLINK = 4'd4;
    localparam logic [3:0] ST_EVCHK  = 4'd5;
    localparam logic [3:0] ST_EV_RD  = 4'd6;
    localparam logic [3:0] ST_EV_TST = 4'd7;
    localparam logic [3:0] ST_INS    = 4'd8;
    localparam logic [3:0] ST_INS2   = 4'd9;

    logic [3:0]         r_state;
    logic [CAP_W-1:0]   r_cap;
    logic [1:0]         r_op;
    logic [ID_BITS-1:0] r_key;
    logic [CW-1:0]      r_idx;
    logic [SW-1:0]      r_pidx;
    logic               r_pv;
    logic [CW-1:0]      r_cur;
    logic [CW-1:0]      r_free;
    logic               r_evict;
    logic               r_ev_valid;
    logic [ID_BITS-1:0] r_ev_id;
    logic [CW-1:0]      r_head;
    logic [CW-1:0]      r_tail;
    logic [CW-1:0]      r_hand;
    logic [CW-1:0]      r_occ;
    logic               r_valid [CAPACITY_MAX];
    logic               r_vis   [CAPACITY_MAX];
    logic               r_done;
    t_rsp               r_rsp;

    logic [SW-1:0]      rd_addr;
    logic [ID_BITS-1:0] id_q;
    logic [CW-1:0]      lh_q;
    logic [CW-1:0]      lt_q;
    logic               id_we;
    logic               lh_we;
    logic [SW-1:0]      lh_wa;
    logic [CW-1:0]      lh_wd;
    logic               lt_we;
    logic [SW-1:0]      lt_wa;
    logic [CW-1:0]      lt_wd;
    logic [EW-1:0]      cap_eff;
    logic               need_evict;
    logic               match;
    logic               cfg_wr;

    // Read address: scan counter during lookup, else the current slot
    assign rd_addr = (r_state == ST_FIND) ? r_idx[SW-1:0] : r_cur[SW-1:0];

    scr_ram #(.W(ID_BITS), .D(CAPACITY_MAX)) u_id_ram (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(r_free[SW-1:0]), .i_wdata(r_key),
        .i_raddr(rd_addr), .o_rdata(id_q)
    );
    scr_ram #(.W(CW), .D(CAPACITY_MAX)) u_lh_ram (
        .i_clk(i_clk), .i_we(lh_we), .i_waddr(lh_wa), .i_wdata(lh_wd),
        .i_raddr(rd_addr), .o_rdata(lh_q)
    );
    scr_ram #(.W(CW), .D(CAPACITY_MAX)) u_lt_ram (
        .i_clk(i_clk), .i_we(lt_we), .i_waddr(lt_wa), .i_wdata(lt_wd),
        .i_raddr(rd_addr), .o_rdata(lt_q)
    );

    // Link memory writes: unlink, prepend, and clearing the new head's link
    always_comb begin
        id_we = (r_state == ST_INS) && (r_free != NIL);
        lh_we = 1'b0;
        lh_wa = r_free[SW-1:0];
        lh_wd = NIL;
        lt_we = 1'b0;
        lt_wa = r_free[SW-1:0];
        lt_wd = r_head;
        case (r_state)
            ST_UNLINK: begin
                lt_we = (lh_q != NIL);
                lt_wa = lh_q[SW-1:0];
                lt_wd = lt_q;
                lh_we = (lt_q != NIL);
                lh_wa = lt_q[SW-1:0];
                lh_wd = lh_q;
            end
            ST_INS: begin
                lt_we = (r_free != NIL);
                lh_we = (r_free != NIL) && (r_head != NIL);
                lh_wa = r_head[SW-1:0];
                lh_wd = r_free;
            end
            ST_INS2: begin
                lh_we = (r_free != NIL);
            end
            default: begin
            end
        endcase
    end

    // Effective capacity, clamped to 1..CAPACITY_MAX
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = EW'(1);
        end else if (EW'(r_cap) > EW'(CAPACITY_MAX)) begin
            cap_eff = EW'(CAPACITY_MAX);
        end else begin
            cap_eff = EW'(r_cap);
        end
    end

    assign need_evict = (EW'(r_occ) >= cap_eff) && (r_occ != '0);
    assign match      = r_pv && r_valid[r_pidx] && (id_q == r_key);
    assign cfg_wr     = psel && penable && pwrite;

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_cap) : '0;
    assign pready = 1'b1;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_hand  <= NIL;
            r_occ   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < CAPACITY_MAX; i++) begin
                r_valid[i] <= 1'b0;
                r_vis[i]   <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_op       <= i_req.operation;
                        r_key      <= ID_BITS'(i_req.object_id);
                        r_idx      <= '0;
                        r_pv       <= 1'b0;
                        r_free     <= NIL;
                        r_ev_valid <= 1'b0;
                        r_ev_id    <= '0;
                        r_state    <= ST_FIND;
                    end
                end
                // one slot per cycle through the id memory
                ST_FIND: begin
                    r_pidx <= r_idx[SW-1:0];
                    r_pv   <= 1'b1;
                    r_idx  <= r_idx + 1'b1;
                    if (r_pv && !r_valid[r_pidx] && (r_free == NIL)) begin
                        r_free <= CW'(r_pidx);
                    end
                    if (match) begin
                        r_cur   <= CW'(r_pidx);
                        r_state <= ST_DISP;
                    end else if (r_pv && (r_pidx == SW'(CAPACITY_MAX - 1))) begin
                        r_cur   <= NIL;
                        r_state <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    r_rsp <= '0;
                    case (r_op)
                        OP_ACCESS: begin
                            if (r_cur != NIL) begin
                                r_vis[r_cur[SW-1:0]] <= 1'b1;
                                r_rsp.hit <= 1'b1;
                                r_done    <= 1'b1;
                                r_state   <= ST_IDLE;
                            end else begin
                                r_state <= ST_EVCHK;
                            end
                        end
                        OP_PROBE: begin
                            r_rsp.hit <= (r_cur != NIL);
                            r_done    <= 1'b1;
                            r_state   <= ST_IDLE;
                        end
                        OP_REMOVE: begin
                            if (r_cur != NIL) begin
                                r_evict <= 1'b0;
                                r_state <= ST_RM_RD;
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= ST_IDLE;
                            end
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_RM_RD: begin
                    r_state <= ST_UNLINK;
                end
                // take r_cur out of the list; links come from the read data
                ST_UNLINK: begin
                    if (lh_q == NIL) begin
                        r_head <= lt_q;
                    end
                    if (lt_q == NIL) begin
                        r_tail <= lh_q;
                    end
                    r_valid[r_cur[SW-1:0]] <= 1'b0;
                    r_vis[r_cur[SW-1:0]]   <= 1'b0;
                    if (r_occ != '0) begin
                        r_occ <= r_occ - 1'b1;
                    end
                    if (r_evict || (r_hand == r_cur)) begin
                        r_hand <= lh_q;
                    end
                    if (r_evict) begin
                        if (!r_ev_valid) begin
                            r_ev_valid <= 1'b1;
                            r_ev_id    <= id_q;
                        end
                        if (r_cur < r_free) begin
                            r_free <= r_cur;
                        end
                        r_state <= ST_EVCHK;
                    end else begin
                        r_rsp         <= '0;
                        r_rsp.hit     <= 1'b1;
                        r_done        <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_EVCHK: begin
                    if (need_evict) begin
                        r_cur   <= (r_hand != NIL) ? r_hand : r_tail;
                        r_evict <= 1'b1;
                        r_state <= ST_EV_RD;
                    end else begin
                        r_state <= ST_INS;
                    end
                end
                ST_EV_RD: begin
                    r_state <= ST_EV_TST;
                end
                // hand step: clear visited and move toward head, wrapping to tail
                ST_EV_TST: begin
                    if (r_vis[r_cur[SW-1:0]]) begin
                        r_vis[r_cur[SW-1:0]] <= 1'b0;
                        r_cur   <= (lh_q != NIL) ? lh_q : r_tail;
                        r_state <= ST_EV_RD;
                    end else begin
                        r_state <= ST_UNLINK;
                    end
                end
                // prepend at head, unvisited
                ST_INS: begin
                    if (r_free != NIL) begin
                        r_valid[r_free[SW-1:0]] <= 1'b1;
                        r_vis[r_free[SW-1:0]]   <= 1'b0;
                        if (r_head == NIL) begin
                            r_tail <= r_free;
                        end
                        r_head <= r_free;
                        r_occ  <= r_occ + 1'b1;
                    end
                    r_state <= ST_INS2;
                end
                ST_INS2: begin
                    r_rsp.hit           <= 1'b0;
                    r_rsp.evicted_valid <= r_ev_valid;
                    r_rsp.evicted_id    <= OBJ_W'(r_ev_id);
                    r_done              <= 1'b1;
                    r_state             <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ----- src/scr_checker.sv -----
// Port-level checker for the SIEVE replacement block, bound to the top level.
// Depends on scr_pkg and sieve_cache_replacement_assert.svh.
`default_nettype none

`include "sieve_cache_replacement_assert.svh"

module scr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire scr_pkg::t_rsp o_rsp
);
    import scr_pkg::*;

    // a result ends the request: block is free in that cycle
    `SCR_ASSERT_NOW(a_done_idle, o_done, !busy, "result while busy")
    // an accepted request keeps the block busy next cycle
    `SCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
    // one result per request, never back to back
    `SCR_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe longer than one cycle")
    // evicted id is zero without an eviction
    `SCR_ASSERT_NOW(a_ev_zero, o_done && !o_rsp.evicted_valid, o_rsp.evicted_id == '0,
        "evicted id without eviction")
    // an eviction only follows a miss
    `SCR_ASSERT_NOW(a_ev_miss, o_done && o_rsp.evicted_valid, !o_rsp.hit, "eviction on hit")

endmodule

bind sieve_cache_replacement scr_checker u_scr_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_done(o_done),
    .o_rsp(o_rsp)
);

`default_nettype wire
